// ===== rtl/ihc_pkg.sv =====
// Shared types and constants of the IPv4 receive header check.
// Used by the top level and the port checker; no dependencies.
package ihc_pkg;

   localparam int unsigned MAX_LOCAL_ADDRS         = 4;
   localparam int unsigned NUM_LOCAL_ADDRS_DEFAULT = 4;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOCAL_ADDR_0      = 3'd0,
      CSR_LOCAL_ADDR_1      = 3'd1,
      CSR_LOCAL_ADDR_2      = 3'd2,
      CSR_LOCAL_ADDR_3      = 3'd3,
      CSR_LOCAL_ADDR_ENABLE = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      VERDICT_ICMP          = 4'd0,
      VERDICT_UDP           = 4'd1,
      VERDICT_TCP           = 4'd2,
      VERDICT_UNKNOWN_PROTO = 4'd3,
      VERDICT_SHORT         = 4'd4,
      VERDICT_VERSION       = 4'd5,
      VERDICT_HDR_LEN       = 4'd6,
      VERDICT_TOTAL_LEN     = 4'd7,
      VERDICT_CHECKSUM      = 4'd8,
      VERDICT_NOT_LOCAL     = 4'd9
   } verdict_type;

   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [3:0]  IP_VERSION    = 4'd4;
   localparam logic [7:0]  LOOPBACK_NET  = 8'd127;
   localparam logic [31:0] BROADCAST     = 32'hFFFF_FFFF;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
   localparam logic [15:0] MIN_HDR_BYTES = 16'd20;

   localparam logic [15:0] IDX_VER_IHL   = 16'd0;
   localparam logic [15:0] IDX_LEN_HI    = 16'd2;
   localparam logic [15:0] IDX_LEN_LO    = 16'd3;
   localparam logic [15:0] IDX_TTL       = 16'd8;
   localparam logic [15:0] IDX_PROTOCOL  = 16'd9;
   localparam logic [15:0] IDX_SRC_FIRST = 16'd12;
   localparam logic [15:0] IDX_SRC_LAST  = 16'd15;
   localparam logic [15:0] IDX_DST_FIRST = 16'd16;
   localparam logic [15:0] IDX_DST_LAST  = 16'd19;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [7:0]  ver_ihl;
      logic [15:0] ip_length;
      logic [7:0]  protocol;
      logic [7:0]  ttl;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] csum;
      logic [7:0]  csum_high;
   } hdr_state_type;

endpackage

// ===== rtl/ihc_req_if.sv =====
// Request channel of the IPv4 receive header check: one packet byte per request.
// Stands alone; no package needed.
interface ihc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ihc_rsp_if.sv =====
// Response channel of the IPv4 receive header check: one verdict per packet.
// Stands alone; no package needed.
interface ihc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [7:0]  protocol;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
   logic [7:0]  ttl;
   logic [5:0]  header_len;
   logic [15:0] data_length;

   modport source (output valid, output verdict, output protocol, output source_ip,
                   output dest_ip, output ttl, output header_len, output data_length,
                   input ready);
   modport sink   (input valid, input verdict, input protocol, input source_ip,
                   input dest_ip, input ttl, input header_len, input data_length,
                   output ready);
endinterface

// ===== rtl/ipv4_rx_header_check.sv =====
// Top level of the IPv4 receive header check: header capture, checksum and verdict.
// Depends on ihc_pkg, ihc_req_if and ihc_rsp_if.
//
//   channel  direction  handshake            contents
//   req_ch   in         valid/ready          data_byte, last_byte
//   rsp_ch   out        valid/ready          verdict and header fields, once per packet
//   csr_*    in         csr_we, no wait      local addresses and their enable mask
//
// One byte is taken per cycle while no verdict waits for rsp_ch.ready; the limit is the
// single header state update per byte. A verdict becomes valid once its last byte has moved
// from the input register into the result register.
// While a verdict waits for rsp_ch.ready, the input register still takes one byte.
// Synchronous reset clears the packet state, the channels and the address registers.
module ipv4_rx_header_check #(
   parameter int unsigned NUM_LOCAL_ADDRS = ihc_pkg::NUM_LOCAL_ADDRS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ihc_req_if.sink                              req_ch,
   ihc_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [ihc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ihc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [31:0]                local_addr_ff [NUM_LOCAL_ADDRS];
   logic [NUM_LOCAL_ADDRS-1:0] addr_enable_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   ihc_pkg::hdr_state_type state_ff;
   ihc_pkg::hdr_state_type state_in;

   logic                 rsp_valid_ff;
   ihc_pkg::verdict_type verdict_ff;
   ihc_pkg::verdict_type verdict_in;
   logic [7:0]           protocol_ff;
   logic [31:0]          src_ff;
   logic [31:0]          dst_ff;
   logic [7:0]           ttl_ff;
   logic [5:0]           hlen_ff;
   logic [5:0]           hlen_in;
   logic [15:0]          payload_ff;
   logic [15:0]          payload_in;

   logic        advance;
   logic        process;
   logic [15:0] idx;
   logic [16:0] csum_sum;
   logic        dst_local;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
            local_addr_ff[i] <= '0;
         end
         addr_enable_ff <= '0;
      end else if (csr_we) begin
         for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
            if (csr_index == ihc_pkg::CSR_INDEX_WIDTH'(i)) begin
               local_addr_ff[i] <= csr_wdata;
            end
         end
         if (csr_index == ihc_pkg::CSR_LOCAL_ADDR_ENABLE) begin
            addr_enable_ff <= csr_wdata[NUM_LOCAL_ADDRS-1:0];
         end
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign process      = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_last_ff <= req_ch.last_byte;
      end
   end

   always_comb begin
      idx      = state_ff.byte_count;
      state_in = state_ff;
      csum_sum = '0;
      priority if (idx == ihc_pkg::IDX_VER_IHL) begin
         state_in.ver_ihl = s1_byte_ff;
      end else if (idx == ihc_pkg::IDX_LEN_HI || idx == ihc_pkg::IDX_LEN_LO) begin
         state_in.ip_length = {state_ff.ip_length[7:0], s1_byte_ff};
      end else if (idx == ihc_pkg::IDX_TTL) begin
         state_in.ttl = s1_byte_ff;
      end else if (idx == ihc_pkg::IDX_PROTOCOL) begin
         state_in.protocol = s1_byte_ff;
      end else if (idx >= ihc_pkg::IDX_SRC_FIRST && idx <= ihc_pkg::IDX_SRC_LAST) begin
         state_in.src = {state_ff.src[23:0], s1_byte_ff};
      end else if (idx >= ihc_pkg::IDX_DST_FIRST && idx <= ihc_pkg::IDX_DST_LAST) begin
         state_in.dst = {state_ff.dst[23:0], s1_byte_ff};
      end else begin
         state_in = state_ff;
      end

      hlen_in = {state_in.ver_ihl[3:0], 2'b00};

      if (idx < {10'b0, hlen_in}) begin
         if (!idx[0]) begin
            state_in.csum_high = s1_byte_ff;
         end else begin
            csum_sum      = {1'b0, state_ff.csum} + {1'b0, state_ff.csum_high, s1_byte_ff};
            state_in.csum = csum_sum[15:0] + {15'b0, csum_sum[16]};
         end
      end

      if (idx != ihc_pkg::COUNT_MAX) begin
         state_in.byte_count = idx + 16'd1;
      end
   end

   always_comb begin
      dst_local = (state_in.dst == ihc_pkg::BROADCAST) ||
                  (state_in.dst[31:24] == ihc_pkg::LOOPBACK_NET);
      for (int i = 0; i < NUM_LOCAL_ADDRS; i++) begin
         if (addr_enable_ff[i] && local_addr_ff[i] == state_in.dst) begin
            dst_local = 1'b1;
         end
      end
   end

   always_comb begin
      priority if (state_in.byte_count < ihc_pkg::MIN_HDR_BYTES) begin
         verdict_in = ihc_pkg::VERDICT_SHORT;
      end else if (state_in.ver_ihl[7:4] != ihc_pkg::IP_VERSION) begin
         verdict_in = ihc_pkg::VERDICT_VERSION;
      end else if ({10'b0, hlen_in} < ihc_pkg::MIN_HDR_BYTES ||
                   {10'b0, hlen_in} > state_in.byte_count) begin
         verdict_in = ihc_pkg::VERDICT_HDR_LEN;
      end else if (state_in.ip_length < {10'b0, hlen_in} ||
                   state_in.ip_length > state_in.byte_count) begin
         verdict_in = ihc_pkg::VERDICT_TOTAL_LEN;
      end else if (state_in.csum != ihc_pkg::CSUM_GOOD) begin
         verdict_in = ihc_pkg::VERDICT_CHECKSUM;
      end else if (!dst_local) begin
         verdict_in = ihc_pkg::VERDICT_NOT_LOCAL;
      end else begin
         unique case (state_in.protocol)
            ihc_pkg::PROTO_ICMP: verdict_in = ihc_pkg::VERDICT_ICMP;
            ihc_pkg::PROTO_UDP:  verdict_in = ihc_pkg::VERDICT_UDP;
            ihc_pkg::PROTO_TCP:  verdict_in = ihc_pkg::VERDICT_TCP;
            default:             verdict_in = ihc_pkg::VERDICT_UNKNOWN_PROTO;
         endcase
      end

      if (verdict_in == ihc_pkg::VERDICT_ICMP || verdict_in == ihc_pkg::VERDICT_UDP ||
          verdict_in == ihc_pkg::VERDICT_TCP) begin
         payload_in = state_in.ip_length - {10'b0, hlen_in};
      end else begin
         payload_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (process) begin
         state_ff <= s1_last_ff ? '0 : state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= process && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process && s1_last_ff) begin
         verdict_ff  <= verdict_in;
         protocol_ff <= state_in.protocol;
         src_ff      <= state_in.src;
         dst_ff      <= state_in.dst;
         ttl_ff      <= state_in.ttl;
         hlen_ff     <= hlen_in;
         payload_ff  <= payload_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.verdict     = verdict_ff;
   assign rsp_ch.protocol    = protocol_ff;
   assign rsp_ch.source_ip   = src_ff;
   assign rsp_ch.dest_ip     = dst_ff;
   assign rsp_ch.ttl         = ttl_ff;
   assign rsp_ch.header_len  = hlen_ff;
   assign rsp_ch.data_length = payload_ff;

endmodule

// ===== rtl/ihc_checker.sv =====
// Port-level assertions for the IPv4 receive header check, bound to the top level.
// Depends on ihc_pkg and on the port names of ipv4_rx_header_check.
module ihc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_verdict,
   input logic [7:0]  rsp_protocol,
   input logic [31:0] rsp_source_ip,
   input logic [31:0] rsp_dest_ip,
   input logic [7:0]  rsp_ttl,
   input logic [5:0]  rsp_header_len,
   input logic [15:0] rsp_data_length
);

   // No verdict is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled verdict keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_verdict, rsp_protocol, rsp_source_ip, rsp_dest_ip, rsp_ttl,
               rsp_header_len, rsp_data_length}))
      else $error("stalled response changed");

   // When the response side drains, a new request is always taken.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // A dropped packet reports no payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != ihc_pkg::VERDICT_ICMP &&
      rsp_verdict != ihc_pkg::VERDICT_UDP && rsp_verdict != ihc_pkg::VERDICT_TCP
      |-> rsp_data_length == 16'd0)
      else $error("payload length on a dropped packet");

   // An ICMP verdict carries the ICMP protocol number and a full header.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == ihc_pkg::VERDICT_ICMP
      |-> rsp_protocol == ihc_pkg::PROTO_ICMP && rsp_header_len >= 6'd20)
      else $error("ICMP verdict with inconsistent header");

endmodule

bind ipv4_rx_header_check ihc_checker u_ihc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_verdict     (rsp_ch.verdict),
   .rsp_protocol    (rsp_ch.protocol),
   .rsp_source_ip   (rsp_ch.source_ip),
   .rsp_dest_ip     (rsp_ch.dest_ip),
   .rsp_ttl         (rsp_ch.ttl),
   .rsp_header_len  (rsp_ch.header_len),
   .rsp_data_length (rsp_ch.data_length)
);
